@@ hdl/phip_pkg.sv @@
// Package for the PCI hardware-ID parser.
// Holds the beat and result types, status codes, keyword tables and hex decode.
// No dependencies.
package phip_pkg;

  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned NUM_KEYS = 4;
  localparam int unsigned KEY_MAX  = 7;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_PREFIX = 2'd1;
  localparam logic [1:0] ST_UNKNOWN    = 2'd2;

  localparam logic [FIELD_W-1:0] SAT_LIMIT = 32'h0FFF_FFFF;
  localparam logic [FIELD_W-1:0] SAT_VALUE = 32'hFFFF_FFFF;

  localparam logic [7:0] CH_AMP = 8'h26;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic [FIELD_W-1:0] vendor_id;
    logic [FIELD_W-1:0] device_id;
    logic [FIELD_W-1:0] subsystem_id;
    logic [FIELD_W-1:0] revision;
    logic [1:0]         status;
  } result_t;

  function automatic logic [7:0] prefix_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = 8'h50;
      2'd1:    c = 8'h43;
      2'd2:    c = 8'h49;
      default: c = 8'h5C;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] key_len(input logic [1:0] k);
    return (k == 2'd2) ? 3'd7 : 3'd4;
  endfunction

  function automatic logic [7:0] key_char(input logic [1:0] k, input logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    case (k)
      2'd0: begin
        case (pos)
          3'd0:    c = 8'h56;
          3'd1:    c = 8'h45;
          3'd2:    c = 8'h4E;
          3'd3:    c = 8'h5F;
          default: c = 8'h00;
        endcase
      end
      2'd1: begin
        case (pos)
          3'd0:    c = 8'h44;
          3'd1:    c = 8'h45;
          3'd2:    c = 8'h56;
          3'd3:    c = 8'h5F;
          default: c = 8'h00;
        endcase
      end
      2'd2: begin
        case (pos)
          3'd0:    c = 8'h53;
          3'd1:    c = 8'h55;
          3'd2:    c = 8'h42;
          3'd3:    c = 8'h53;
          3'd4:    c = 8'h59;
          3'd5:    c = 8'h53;
          3'd6:    c = 8'h5F;
          default: c = 8'h00;
        endcase
      end
      default: begin
        case (pos)
          3'd0:    c = 8'h52;
          3'd1:    c = 8'h45;
          3'd2:    c = 8'h56;
          3'd3:    c = 8'h5F;
          default: c = 8'h00;
        endcase
      end
    endcase
    return c;
  endfunction

  // Returns {is_hex, digit}.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    logic [7:0] t;
    r = 5'd0;
    t = 8'd0;
    if (c inside {[8'h30:8'h39]}) begin
      t = c - 8'h30;
      r = {1'b1, t[3:0]};
    end else if (c inside {[8'h61:8'h66]}) begin
      t = c - 8'h57;
      r = {1'b1, t[3:0]};
    end else if (c inside {[8'h41:8'h46]}) begin
      t = c - 8'h37;
      r = {1'b1, t[3:0]};
    end
    return r;
  endfunction

endpackage

@@ hdl/phip_in_reg.sv @@
// Input register of the PCI hardware-ID parser.
// Captures one character beat and holds it until the parse stage takes it.
// Depends on phip_pkg.
module phip_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          advance,
  input  phip_pkg::beat_t beat_in,
  output logic          s1_valid,
  output phip_pkg::beat_t beat_q
);
  import phip_pkg::*;

  logic take;

  assign take = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      beat_q <= beat_in;
    end
  end

endmodule

@@ hdl/phip_core.sv @@
// Parse stage of the PCI hardware-ID parser.
// Holds the prefix, keyword and value state and updates it once per beat.
// Depends on phip_pkg.
module phip_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  phip_pkg::beat_t   beat,
  output phip_pkg::result_t result
);
  import phip_pkg::*;

  typedef enum logic [2:0] {
    PH_PREFIX,
    PH_KEY,
    PH_VALUE,
    PH_SKIP,
    PH_STOPPED,
    PH_BAD
  } phase_t;

  phase_t             phase, phase_next;
  logic [2:0]         match_pos, match_pos_next;
  logic [3:0]         key_candidates, key_candidates_next;
  logic [1:0]         target_field, target_field_next;
  logic [FIELD_W-1:0] fields [NUM_KEYS];
  logic [FIELD_W-1:0] fields_next [NUM_KEYS];

  logic [3:0]         keep;
  logic [2:0]         pos_inc;
  logic               key_done;
  logic [1:0]         key_hit;
  logic [4:0]         hex;
  logic [FIELD_W-1:0] cur;

  always_comb begin
    phase_next          = phase;
    match_pos_next      = match_pos;
    key_candidates_next = key_candidates;
    target_field_next   = target_field;
    for (int i = 0; i < NUM_KEYS; i++) begin
      fields_next[i] = fields[i];
    end
    keep     = 4'd0;
    pos_inc  = match_pos + 3'd1;
    key_done = 1'b0;
    key_hit  = 2'd0;
    hex      = hex_decode(beat.ch);
    cur      = fields[target_field];

    case (phase)
      PH_PREFIX: begin
        if (match_pos[2] == 1'b0 && beat.ch == prefix_char(match_pos[1:0])) begin
          if (match_pos == 3'd3) begin
            phase_next          = PH_KEY;
            match_pos_next      = 3'd0;
            key_candidates_next = 4'hF;
          end else begin
            match_pos_next = pos_inc;
          end
        end else begin
          phase_next = PH_BAD;
        end
      end
      PH_KEY: begin
        for (int k = 0; k < NUM_KEYS; k++) begin
          if (key_candidates[k] && match_pos < key_len(2'(k)) &&
              key_char(2'(k), match_pos) == beat.ch) begin
            keep[k] = 1'b1;
          end
        end
        key_candidates_next = keep;
        if (keep == 4'd0) begin
          phase_next = PH_STOPPED;
        end else begin
          match_pos_next = pos_inc;
          for (int k = NUM_KEYS - 1; k >= 0; k--) begin
            if (keep[k] && pos_inc == key_len(2'(k))) begin
              key_done = 1'b1;
              key_hit  = 2'(k);
            end
          end
          if (key_done) begin
            target_field_next    = key_hit;
            fields_next[key_hit] = '0;
            phase_next           = PH_VALUE;
          end
        end
      end
      PH_VALUE: begin
        if (beat.ch == CH_AMP) begin
          phase_next          = PH_KEY;
          match_pos_next      = 3'd0;
          key_candidates_next = 4'hF;
        end else if (!hex[4]) begin
          phase_next = PH_SKIP;
        end else if (cur > SAT_LIMIT) begin
          fields_next[target_field] = SAT_VALUE;
        end else begin
          fields_next[target_field] = {cur[FIELD_W-5:0], hex[3:0]};
        end
      end
      PH_SKIP: begin
        if (beat.ch == CH_AMP) begin
          phase_next          = PH_KEY;
          match_pos_next      = 3'd0;
          key_candidates_next = 4'hF;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (phase_next == PH_PREFIX || phase_next == PH_BAD) begin
      result.status = ST_BAD_PREFIX;
    end else if (phase_next == PH_KEY || phase_next == PH_STOPPED) begin
      result.status = ST_UNKNOWN;
    end else begin
      result.status = ST_OK;
    end
    if (result.status == ST_BAD_PREFIX) begin
      result.vendor_id    = '0;
      result.device_id    = '0;
      result.subsystem_id = '0;
      result.revision     = '0;
    end else begin
      result.vendor_id    = fields_next[0];
      result.device_id    = fields_next[1];
      result.subsystem_id = fields_next[2];
      result.revision     = fields_next[3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && beat.last)) begin
      phase          <= PH_PREFIX;
      match_pos      <= 3'd0;
      key_candidates <= 4'hF;
      target_field   <= 2'd0;
      for (int i = 0; i < NUM_KEYS; i++) begin
        fields[i] <= '0;
      end
    end else if (step) begin
      phase          <= phase_next;
      match_pos      <= match_pos_next;
      key_candidates <= key_candidates_next;
      target_field   <= target_field_next;
      for (int i = 0; i < NUM_KEYS; i++) begin
        fields[i] <= fields_next[i];
      end
    end
  end

endmodule

@@ hdl/phip_out_reg.sv @@
// Result register of the PCI hardware-ID parser.
// Holds one finished result beat until the receiver takes it.
// Depends on phip_pkg.
module phip_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  phip_pkg::result_t result_in,
  input  logic              out_stall,
  output logic              out_valid,
  output phip_pkg::result_t result_q
);
  import phip_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_q <= result_in;
    end
  end

endmodule

@@ hdl/pci_hardware_id_parser.sv @@
// Top level of the PCI hardware-ID parser.
// Depends on phip_pkg, phip_in_reg, phip_core and phip_out_reg.
//
// The input channel carries one ASCII character per beat (ch, with last on
// the final character of an ID string). The string must start with the PCI
// prefix and a backslash, then tokens split at '&' that start with VEN_,
// DEV_, SUBSYS_ or REV_; the hex digits after each keyword fill that field.
// The output channel carries one result beat per string: the four fields
// and a status (ok, bad prefix, or stopped at an unknown token).
// A character beat is taken in every cycle in which in_stall is low. Once
// the last character of a string is accepted, it is held in the input
// register, and the combinational parse logic then writes the result of the
// string into the result register.
// Throughput is one character per cycle while in_stall is low, set by the single parse stage.
// While the receiver stalls with a result held, characters keep flowing
// until the next last character reaches the parse stage; in_stall then
// rises until the result register is free.
// Reset clears both valid flags and returns the parser to prefix matching.
module pci_hardware_id_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  ch,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] vendor_id,
  output logic [31:0] device_id,
  output logic [31:0] subsystem_id,
  output logic [31:0] revision,
  output logic [1:0]  status
);
  import phip_pkg::*;

  beat_t   beat_in, beat_q;
  result_t result_d, result_q;
  logic    s1_valid, advance, out_free, step;

  assign beat_in.ch   = ch;
  assign beat_in.last = last;

  assign out_free = !out_valid || !out_stall;
  assign advance  = !s1_valid || !beat_q.last || out_free;
  assign step     = s1_valid && advance;
  assign in_stall = !advance;

  phip_in_reg u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .advance  (advance),
    .beat_in  (beat_in),
    .s1_valid (s1_valid),
    .beat_q   (beat_q)
  );

  phip_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .beat   (beat_q),
    .result (result_d)
  );

  phip_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step && beat_q.last),
    .result_in (result_d),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .result_q  (result_q)
  );

  assign vendor_id    = result_q.vendor_id;
  assign device_id    = result_q.device_id;
  assign subsystem_id = result_q.subsystem_id;
  assign revision     = result_q.revision;
  assign status       = result_q.status;

endmodule

@@ hdl/phip_checker.sv @@
// Port checker for the PCI hardware-ID parser, bound to the top level.
// Depends on phip_pkg and pci_hardware_id_parser.
module phip_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] vendor_id,
  input logic [31:0] device_id,
  input logic [31:0] subsystem_id,
  input logic [31:0] revision,
  input logic [1:0]  status
);
  import phip_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(vendor_id) &&
      $stable(device_id) && $stable(subsystem_id) && $stable(revision))
    else $error("stalled result beat changed");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat valid right after reset");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_BAD_PREFIX |->
      vendor_id == '0 && device_id == '0 && subsystem_id == '0 && revision == '0)
    else $error("bad prefix result carries nonzero fields");

  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == ST_OK || status == ST_BAD_PREFIX || status == ST_UNKNOWN)
    else $error("undefined status code");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while the result register is free");

endmodule

bind pci_hardware_id_parser phip_checker u_chk (.*);
